@@ hdl/eed_pkg.sv @@
// Shared types and constants of the echo escape decoder.
package eed_pkg;

  // Request op codes
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_ARG  = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ESCAPES  = 1'b0;
  localparam logic CFG_SUPPRESS = 1'b1;

  // Characters
  localparam logic [7:0] CH_BSL = 8'h5c;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_NL  = 8'h0a;
  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_X   = 8'h78;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Digit limits of numeric escapes
  localparam logic [1:0] OCT_DIGITS = 2'd3;
  localparam logic [1:0] HEX_DIGITS = 2'd2;

  // Output bytes produced by one request: count of 0 to 3 plus the bytes
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
  } job_t;

endpackage

@@ hdl/eed_req_if.sv @@
// Request channel: op code and argument byte with valid/ready.
interface eed_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

@@ hdl/eed_rsp_if.sv @@
// Result channel: one decoded byte and end-of-run flag with valid/ready.
interface eed_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

@@ hdl/eed_front.sv @@
// Front end: accepts requests, tracks escape state, builds output byte groups.
module eed_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic           cfg_data_i,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  logic [1:0]     req_op_i,
  input  logic [7:0]     req_data_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output eed_pkg::job_t  q_job_o
);
  import eed_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_BSL  = 2'd1,
    MODE_OCT  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [1:0] dcnt_q, dcnt_d;
  logic [7:0] acc_q, acc_d;
  logic       seen_q, seen_d;
  logic       esc_en_q, supp_q;

  logic       accept;
  job_t       job;
  logic [1:0] fl_n;
  logic [7:0] fl_b0, fl_b1;
  logic       dig_ok;
  logic [3:0] dig_val;
  logic [7:0] acc_new;
  logic [1:0] dcnt_new;
  logic [1:0] dig_lim;

  // Decode a hex digit: valid flag and value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  assign req_ready_o = !q_full_i;
  assign accept      = req_valid_i && req_ready_o;
  assign q_push_o    = accept && (job.cnt != 2'd0);
  assign q_job_o     = job;

  // Bytes that flush a pending escape
  always_comb begin
    fl_n  = 2'd0;
    fl_b0 = CH_BSL;
    fl_b1 = CH_X;
    case (mode_q)
      MODE_BSL: fl_n = 2'd1;
      MODE_OCT: begin
        fl_n  = 2'd1;
        fl_b0 = acc_q;
      end
      MODE_HEX: begin
        if (dcnt_q == 2'd0) begin
          fl_n = 2'd2;
        end else begin
          fl_n  = 2'd1;
          fl_b0 = acc_q;
        end
      end
      default: fl_n = 2'd0;
    endcase
  end

  // Digit arithmetic of the pending numeric escape
  always_comb begin
    {dig_ok, dig_val} = hex_digit(req_data_i);
    if (mode_q == MODE_OCT) begin
      dig_ok  = (req_data_i >= 8'h30) && (req_data_i <= 8'h37);
      acc_new = {acc_q[4:0], 3'b000} + {4'b0000, dig_val};
      dig_lim = OCT_DIGITS;
    end else begin
      acc_new = {acc_q[3:0], 4'b0000} + {4'b0000, dig_val};
      dig_lim = HEX_DIGITS;
    end
    dcnt_new = dcnt_q + 2'd1;
  end

  // Classify the request and update escape state
  always_comb begin
    mode_d = mode_q;
    dcnt_d = dcnt_q;
    acc_d  = acc_q;
    seen_d = seen_q;
    job    = '0;
    case (req_op_i)
      OP_BYTE: begin
        seen_d = 1'b1;
        case (mode_q)
          MODE_IDLE: begin
            if (esc_en_q && req_data_i == CH_BSL) begin
              mode_d = MODE_BSL;
            end else begin
              job.cnt     = 2'd1;
              job.data[0] = req_data_i;
            end
          end
          MODE_BSL: begin
            mode_d      = MODE_IDLE;
            dcnt_d      = 2'd0;
            acc_d       = 8'h00;
            job.cnt     = 2'd1;
            job.data[0] = CH_NUL;
            case (req_data_i)
              8'h61: job.data[0] = 8'h07;
              8'h62: job.data[0] = 8'h08;
              8'h63: job.data[0] = CH_NUL;
              8'h65, 8'h45: job.data[0] = CH_ESC;
              8'h66: job.data[0] = 8'h0c;
              8'h6e: job.data[0] = CH_NL;
              8'h72: job.data[0] = 8'h0d;
              8'h74: job.data[0] = 8'h09;
              8'h76: job.data[0] = 8'h0b;
              CH_BSL: job.data[0] = CH_BSL;
              8'h30: begin
                mode_d  = MODE_OCT;
                job.cnt = 2'd0;
              end
              CH_X: begin
                mode_d  = MODE_HEX;
                job.cnt = 2'd0;
              end
              default: begin
                job.cnt     = 2'd2;
                job.data[0] = CH_BSL;
                job.data[1] = req_data_i;
              end
            endcase
          end
          default: begin
            if (dig_ok) begin
              if (dcnt_new >= dig_lim) begin
                job.cnt     = 2'd1;
                job.data[0] = acc_new;
                mode_d      = MODE_IDLE;
                dcnt_d      = 2'd0;
                acc_d       = 8'h00;
              end else begin
                acc_d  = acc_new;
                dcnt_d = dcnt_new;
              end
            end else begin
              // Flush the escape, then treat the byte as a fresh one
              job.data[0] = fl_b0;
              job.data[1] = fl_b1;
              job.cnt     = fl_n;
              mode_d      = MODE_IDLE;
              dcnt_d      = 2'd0;
              acc_d       = 8'h00;
              if (esc_en_q && req_data_i == CH_BSL) begin
                mode_d = MODE_BSL;
              end else begin
                job.data[fl_n] = req_data_i;
                job.cnt        = fl_n + 2'd1;
              end
            end
          end
        endcase
      end
      OP_ARG: begin
        job.data[0] = fl_b0;
        job.data[1] = fl_b1;
        job.cnt     = fl_n;
        mode_d      = MODE_IDLE;
        dcnt_d      = 2'd0;
        acc_d       = 8'h00;
        if (seen_q) begin
          job.data[fl_n] = CH_SP;
          job.cnt        = fl_n + 2'd1;
        end
        seen_d = 1'b1;
      end
      OP_END: begin
        job.data[0] = fl_b0;
        job.data[1] = fl_b1;
        job.cnt     = fl_n;
        mode_d      = MODE_IDLE;
        dcnt_d      = 2'd0;
        acc_d       = 8'h00;
        if (!supp_q) begin
          job.data[fl_n] = CH_NL;
          job.cnt        = fl_n + 2'd1;
        end
        seen_d = 1'b0;
      end
      default: job = '0;
    endcase
  end

  // Hold state; advance on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      dcnt_q <= 2'd0;
      acc_q  <= 8'h00;
      seen_q <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      dcnt_q <= dcnt_d;
      acc_q  <= acc_d;
      seen_q <= seen_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_en_q <= 1'b0;
      supp_q   <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ESCAPES) esc_en_q <= cfg_data_i;
      if (cfg_idx_i == CFG_SUPPRESS) supp_q <= cfg_data_i;
    end
  end

endmodule

@@ hdl/eed_queue.sv @@
// Short queue of byte groups between front end and back end.
module eed_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  eed_pkg::job_t  push_job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output eed_pkg::job_t  head_o
);
  import eed_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store pushed groups
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_job_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ hdl/eed_back.sv @@
// Back end: sends group bytes one per cycle unless stalled, via an output register.
module eed_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  eed_pkg::job_t  q_head_i,
  output logic           q_pop_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output logic [7:0]     rsp_byte_o,
  output logic           rsp_last_o
);
  import eed_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic [1:0] idx_q;
  logic       load;
  logic       is_last;

  assign rsp_valid_o = valid_q;
  assign rsp_byte_o  = byte_q;
  assign rsp_last_o  = last_q;

  assign load    = q_valid_i && (!valid_q || rsp_ready_i);
  assign is_last = (idx_q + 2'd1) == q_head_i.cnt;
  assign q_pop_o = load && is_last;

  // Control: output valid and byte index within the group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (rsp_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= q_head_i.data[idx_q];
      last_q <= is_last;
    end
  end

endmodule

@@ hdl/echo_escape_decoder_core.sv @@
// Top level of the echo escape decoder.
//
// Requests arrive on req_i: op 0 carries an argument byte, op 1 starts the
// next argument, op 2 ends the command. Each request yields zero to three
// output bytes on rsp_o, the last of them flagged by last_of_run. Spaces
// between arguments, backslash escape decoding and the closing newline are
// produced here; cfg_we_i/cfg_idx_i/cfg_data_i write escapes_enabled
// (index 0) and suppress_newline (index 1); the user must write them only
// while the block is idle; the block itself does not enforce this.
// A request is taken every cycle while the group queue has room. The first
// byte of a request goes through a queue entry and the output register
// before it is valid on rsp_o. The back end sends one byte per cycle while
// rsp_o is ready, so a request that yields two or three bytes holds the
// output for each of its bytes; the QueueDepth-entry queue absorbs these
// runs and lets the input keep flowing meanwhile. When rsp_o stalls, the
// output byte holds, the queue fills and then req_i drops ready. Reset
// clears the escape state, the configuration and the queue; no request is
// lost or repeated across stalls.
module echo_escape_decoder_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i,
  eed_req_if.sink     req_i,
  eed_rsp_if.source   rsp_o
);
  import eed_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  job_t q_job, q_head;

  // Accept and classify requests
  eed_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_op_i    (req_i.op),
    .req_data_i  (req_i.data_byte),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (q_job)
  );

  // Buffer byte groups
  eed_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // Send bytes
  eed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_byte_o  (rsp_o.out_byte),
    .rsp_last_o  (rsp_o.last_of_run)
  );

endmodule
